FILE: sv/p24bd_pkg.sv
// Package for the 24-bit PRESENT-style block decryptor.
// Holds widths, codes, the sequencer state type and the round functions.
// Used by every module of the block; depends on nothing.
package p24bd_pkg;

  localparam int ROUNDS      = 10;
  localparam int KEY_COUNT   = ROUNDS + 1;
  localparam int KEY_AW      = $clog2(KEY_COUNT);
  localparam int BLOCK_W     = 24;
  localparam int NIBBLES     = BLOCK_W / 4;
  localparam int KEY_INDEX_W = 4;
  localparam int IN_FIELDS_W = KEY_INDEX_W + 2 * BLOCK_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((BLOCK_W + 7) / 8) * 8;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_DECRYPT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WHITEN,
    ST_ROUND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                en;
    logic [KEY_AW-1:0]   addr;
    logic [BLOCK_W-1:0]  data;
  } key_wr_t;

  function automatic logic [3:0] inv_sbox(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0: y = 4'h5;
      4'h1: y = 4'hE;
      4'h2: y = 4'hF;
      4'h3: y = 4'h8;
      4'h4: y = 4'hC;
      4'h5: y = 4'h1;
      4'h6: y = 4'h2;
      4'h7: y = 4'hD;
      4'h8: y = 4'hB;
      4'h9: y = 4'h4;
      4'hA: y = 4'h6;
      4'hB: y = 4'h3;
      4'hC: y = 4'h0;
      4'hD: y = 4'h7;
      4'hE: y = 4'h9;
      4'hF: y = 4'hA;
      default: y = 4'h0;
    endcase
    return y;
  endfunction

  // Bit i counted from the MSB moves to MSB-counted position 4*(i mod 6) + i/6.
  function automatic logic [BLOCK_W-1:0] inv_perm(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] r;
    r = '0;
    for (int i = 0; i < BLOCK_W; i++) begin
      r[BLOCK_W-1-(4*(i%NIBBLES)+i/NIBBLES)] = s[BLOCK_W-1-i];
    end
    return r;
  endfunction

  function automatic logic [BLOCK_W-1:0] inv_sub(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] r;
    for (int n = 0; n < NIBBLES; n++) begin
      r[4*n +: 4] = inv_sbox(s[4*n +: 4]);
    end
    return r;
  endfunction

endpackage

FILE: sv/present24_block_decrypt_unit.sv
// Top level of the 24-bit PRESENT-style block decryptor.
// Holds the sequencer, the output register and the instances of the key store and round unit.
// Depends on p24bd_pkg, p24bd_key_ram and p24bd_round.
//
// The input channel carries one word per item. A word with tuser low loads
// a round key: key_index selects the slot and key_value is stored. A load
// gives no output word, and an index above the last round is dropped. A
// word with tuser high decrypts cipher_block and gives one output word
// holding plain_block.
// A decrypt first XORs the last round key, then runs ten rounds through a
// single round unit, one round per cycle, reading one key per cycle from the
// key store. The output word appears in the same cycle that the sequencer
// returns to idle, where the next input word can be taken. Input tready is
// low while a decrypt is in progress. If the receiver stalls, the finished
// result waits in the output register; a further decrypt can run meanwhile
// and then waits in its last step until the output register is free.
// Reset clears the sequencer and the output valid. Round keys are not
// cleared and must all be loaded before the first decrypt.
module present24_block_decrypt_unit
  import p24bd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // Fields from bit 0 up: key_index, key_value, cipher_block, zero pad.
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0 up: action.
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // Fields from bit 0 up: plain_block.
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [KEY_INDEX_W-1:0] key_index;
  logic [BLOCK_W-1:0]     key_value;
  logic [BLOCK_W-1:0]     cipher_block;

  state_t             fsm, fsm_next;
  logic [BLOCK_W-1:0] blk, blk_next;
  logic [KEY_AW-1:0]  rnd, rnd_next;
  logic [KEY_AW-1:0]  raddr;
  logic [BLOCK_W-1:0] key_rdata;
  logic [BLOCK_W-1:0] round_out;
  logic               load_out;
  logic               out_valid;
  logic [BLOCK_W-1:0] out_data;
  key_wr_t            key_wr;

  assign key_index    = s_axis_tdata[KEY_INDEX_W-1:0];
  assign key_value    = s_axis_tdata[KEY_INDEX_W +: BLOCK_W];
  assign cipher_block = s_axis_tdata[KEY_INDEX_W+BLOCK_W +: BLOCK_W];

  assign key_wr.en   = s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_LOAD)
                       && (key_index <= KEY_INDEX_W'(ROUNDS));
  assign key_wr.addr = KEY_AW'(key_index);
  assign key_wr.data = key_value;

  p24bd_key_ram u_key_ram (
    .clk   (clk),
    .wr    (key_wr),
    .raddr (raddr),
    .rdata (key_rdata)
  );

  p24bd_round u_round (
    .blk    (blk),
    .key    (key_rdata),
    .result (round_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm <= ST_IDLE;
    end else begin
      fsm <= fsm_next;
    end
  end

  always_ff @(posedge clk) begin
    blk <= blk_next;
    rnd <= rnd_next;
  end

  always_comb begin
    fsm_next      = fsm;
    blk_next      = blk;
    rnd_next      = rnd;
    raddr         = '0;
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    case (fsm)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && (s_axis_tuser == ACT_DECRYPT)) begin
          blk_next = cipher_block;
          rnd_next = KEY_AW'(ROUNDS - 1);
          raddr    = KEY_AW'(ROUNDS);
          fsm_next = ST_WHITEN;
        end
      end
      ST_WHITEN: begin
        blk_next = blk ^ key_rdata;
        raddr    = rnd;
        fsm_next = ST_ROUND;
      end
      ST_ROUND: begin
        blk_next = round_out;
        if (rnd == '0) begin
          fsm_next = ST_DONE;
        end else begin
          rnd_next = rnd - 1'b1;
          raddr    = rnd - 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid || m_axis_tready) begin
          load_out = 1'b1;
          fsm_next = ST_IDLE;
        end
      end
      default: begin
        fsm_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= blk;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_W'(out_data);

endmodule

FILE: sv/p24bd_key_ram.sv
// Round key store for the 24-bit block decryptor.
// One write port and one registered read port; contents are undefined until written.
// Depends on p24bd_pkg.
module p24bd_key_ram
  import p24bd_pkg::*;
(
  input  logic               clk,
  input  key_wr_t            wr,
  input  logic [KEY_AW-1:0]  raddr,
  output logic [BLOCK_W-1:0] rdata
);

  logic [BLOCK_W-1:0] mem [KEY_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/p24bd_round.sv
// Shared round unit of the 24-bit block decryptor.
// Inverse bit permutation, inverse S-box layer and round key addition.
// Depends on p24bd_pkg.
module p24bd_round
  import p24bd_pkg::*;
(
  input  logic [BLOCK_W-1:0] blk,
  input  logic [BLOCK_W-1:0] key,
  output logic [BLOCK_W-1:0] result
);

  assign result = inv_sub(inv_perm(blk)) ^ key;

endmodule
